### hdl/pixel_hue_sat_contrast_bright_assert.svh
// assertion macros used by the checker file of the pixel adjust block
// depends on nothing; included by bare file name
`ifndef PIXEL_HUE_SAT_CONTRAST_BRIGHT_ASSERT_SVH
`define PIXEL_HUE_SAT_CONTRAST_BRIGHT_ASSERT_SVH

// same-cycle implication, off during reset
`define PHSCB_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("phscb same-cycle check failed");

// next-cycle implication, off during reset
`define PHSCB_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("phscb next-cycle check failed");

`endif

### hdl/phscb_pkg.sv
// shared types and constants of the pixel hue/saturation/contrast/brightness block
// depends on nothing
package phscb_pkg;

   // component width and full scale
   localparam int COMPONENT_BITS = 15;
   localparam logic [14:0] FULL_SCALE = 15'h7fff;

   // register port
   localparam int CSR_INDEX_BITS = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_HUE_SHIFT         = 4'd0,
      CSR_SATURATION_GAIN   = 4'd1,
      CSR_CONTRAST_GAIN     = 4'd2,
      CSR_BRIGHTNESS_OFFSET = 4'd3
   } csr_index_type;

   // hue sector base of the largest component
   typedef enum logic [1:0] {
      HUE_BASE_RED   = 2'd0,
      HUE_BASE_GREEN = 2'd1,
      HUE_BASE_BLUE  = 2'd2
   } hue_base_type;

   // hue in 1/64 degree
   localparam logic [17:0] HUE_FULL  = 18'd23040;
   localparam logic [17:0] HUE_SIXTH = 18'd3840;

   // luma weights, q12
   localparam logic [26:0] LUMA_R = 27'd1264;
   localparam logic [26:0] LUMA_G = 27'd2496;
   localparam logic [26:0] LUMA_B = 27'd336;

   // reciprocal of 15 scaled by 2^24, used for f * 65536 / 3840
   localparam logic [32:0] RECIP_FIFTEEN = 33'd1118482;

   typedef struct packed {
      logic [14:0] red_in;
      logic [14:0] green_in;
      logic [14:0] blue_in;
      logic [15:0] alpha_in;
   } req_data_type;

   typedef struct packed {
      logic [14:0] red_out;
      logic [14:0] green_out;
      logic [14:0] blue_out;
      logic [15:0] alpha_out;
   } rsp_data_type;

endpackage

### hdl/pixel_hue_sat_contrast_bright.sv
// pixel hue, saturation, contrast and brightness adjustment, 14-stage pipeline
// depends on phscb_pkg
//
// Usage:
//   req channel: one rgba pixel per transfer (req_valid/req_ready, req_data).
//   rsp channel: one adjusted pixel per transfer (rsp_valid/rsp_ready, rsp_data).
//   csr channel: register writes (csr_index, csr_data); always ready, write only
//     while the pipeline is empty.
//   Throughput: one pixel per cycle while rsp is not stalled; each stage holds one
//     pixel, the hue quotient takes four of them (three quotient bits per stage).
//   Reset clears all stage valid bits and loads the register defaults
//     (no hue shift, unit saturation and contrast, zero brightness).
//   When the receiver stalls the result is held on rsp; empty stages upstream
//     still take new pixels, and req_ready drops only when all 14 stages are full.
//   Hue shift of zero bypasses the hsv rotation; alpha is carried unchanged.
module pixel_hue_sat_contrast_bright (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  phscb_pkg::req_data_type                req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output phscb_pkg::rsp_data_type                rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [phscb_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [15:0]                            csr_data
);
   import phscb_pkg::*;

   localparam int NUM_STAGES = 14;

   typedef struct packed {
      logic [14:0]  r;
      logic [14:0]  g;
      logic [14:0]  b;
      logic [15:0]  a;
      logic [14:0]  mx;
      logic [14:0]  mn;
      logic [14:0]  d;
      logic         neg;
      logic         dz;
      hue_base_type base;
      logic [11:0]  numlo;
   } hue_carry_type;

   typedef struct packed {
      logic [14:0] r;
      logic [14:0] g;
      logic [14:0] b;
   } rgb_type;

   // three restoring division steps
   function automatic logic [17:0] div3(input logic [14:0] rem, input logic [14:0] den,
                                        input logic [2:0] bits);
      logic [15:0] t;
      logic [14:0] r;
      logic [2:0]  q;
      r = rem;
      q = '0;
      for (int i = 2; i >= 0; i--) begin
         t = {r, bits[i]};
         if (t >= {1'b0, den}) begin
            t = t - {1'b0, den};
            q[i] = 1'b1;
         end
         r = t[14:0];
      end
      return {r, q};
   endfunction

   // configuration registers
   logic signed [15:0] hue_shift_ff;
   logic signed [15:0] sat_gain_ff;
   logic signed [15:0] con_gain_ff;
   logic signed [15:0] bri_off_ff;
   logic signed [61:0] offset_ff;
   logic signed [61:0] offset_in;
   logic signed [18:0] off_factor;
   logic signed [33:0] off_scaled;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_shift_ff <= 16'sd0;
         sat_gain_ff  <= 16'sd4096;
         con_gain_ff  <= 16'sd4096;
         bri_off_ff   <= 16'sd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HUE_SHIFT:         hue_shift_ff <= csr_data;
            CSR_SATURATION_GAIN:   sat_gain_ff  <= csr_data;
            CSR_CONTRAST_GAIN:     con_gain_ff  <= csr_data;
            CSR_BRIGHTNESS_OFFSET: bri_off_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // brightness/contrast offset, ((4096 - c) + 2b) * fs * 2^23
   always_comb begin
      off_factor = $signed(19'd4096) - {{3{con_gain_ff[15]}}, con_gain_ff}
                   + {{2{bri_off_ff[15]}}, bri_off_ff, 1'b0};
      off_scaled = {off_factor, 15'd0} - {{15{off_factor[18]}}, off_factor};
      offset_in  = {{5{off_scaled[33]}}, off_scaled, 23'd0};
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
   end

   // stage valid bits and per-stage advance
   logic [NUM_STAGES:1] valid_ff;
   logic [NUM_STAGES:1] valid_in;
   logic [NUM_STAGES:1] adv;

   always_comb begin
      adv[NUM_STAGES] = !valid_ff[NUM_STAGES] || rsp_ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign valid_in  = {valid_ff[NUM_STAGES-1:1], req_valid};
   assign req_ready = adv[1];
   assign rsp_valid = valid_ff[NUM_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // stage 1: max, min, hue numerator
   logic [14:0]        s0_r, s0_g, s0_b;
   logic               red_max, green_max;
   logic signed [15:0] hue_diff;
   logic [14:0]        diff_mag;
   logic [26:0]        hue_num;
   hue_carry_type      carry_in;

   assign s0_r = req_data.red_in;
   assign s0_g = req_data.green_in;
   assign s0_b = req_data.blue_in;

   always_comb begin
      red_max   = (s0_r >= s0_g) && (s0_r >= s0_b);
      green_max = !red_max && (s0_g >= s0_b);
      carry_in.r = s0_r;
      carry_in.g = s0_g;
      carry_in.b = s0_b;
      carry_in.a = req_data.alpha_in;
      if (red_max) begin
         carry_in.mx   = s0_r;
         carry_in.base = HUE_BASE_RED;
         hue_diff      = $signed({1'b0, s0_g}) - $signed({1'b0, s0_b});
      end else if (green_max) begin
         carry_in.mx   = s0_g;
         carry_in.base = HUE_BASE_GREEN;
         hue_diff      = $signed({1'b0, s0_b}) - $signed({1'b0, s0_r});
      end else begin
         carry_in.mx   = s0_b;
         carry_in.base = HUE_BASE_BLUE;
         hue_diff      = $signed({1'b0, s0_r}) - $signed({1'b0, s0_g});
      end
      if ((s0_r <= s0_g) && (s0_r <= s0_b)) begin
         carry_in.mn = s0_r;
      end else if (s0_g <= s0_b) begin
         carry_in.mn = s0_g;
      end else begin
         carry_in.mn = s0_b;
      end
      carry_in.d   = carry_in.mx - carry_in.mn;
      carry_in.dz  = (carry_in.d == 15'd0);
      carry_in.neg = hue_diff[15];
      diff_mag     = hue_diff[15] ? 15'(-hue_diff) : hue_diff[14:0];
      // times 3840 = 4096 - 256
      hue_num        = {diff_mag, 12'd0} - {4'd0, diff_mag, 8'd0};
      carry_in.numlo = hue_num[11:0];
   end

   hue_carry_type carry_ff [1:8];
   logic [14:0]   rem_ff   [1:4];
   logic [11:0]   quo_ff   [1:5];

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         carry_ff[1] <= carry_in;
         rem_ff[1]   <= hue_num[26:12];
         quo_ff[1]   <= '0;
      end
   end

   // carry the pixel context along the hue stages
   for (genvar k = 2; k <= 8; k++) begin : g_carry
      always_ff @(posedge clock) begin
         if (adv[k]) begin
            carry_ff[k] <= carry_ff[k-1];
         end
      end
   end

   // stages 2 to 5: hue quotient, three bits per stage
   for (genvar j = 2; j <= 5; j++) begin : g_div
      logic [17:0] step;
      assign step = div3(rem_ff[j-1], carry_ff[j-1].d,
                         carry_ff[j-1].numlo[11-3*(j-2) -: 3]);
      always_ff @(posedge clock) begin
         if (adv[j]) begin
            quo_ff[j] <= {quo_ff[j-1][8:0], step[2:0]};
         end
      end
      // the last step leaves no remainder to pass on
      if (j < 5) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv[j]) begin
               rem_ff[j] <= step[17:3];
            end
         end
      end
   end

   // stage 6: add sector base and shift, wrap to one turn
   logic [11:0]        quo_val;
   logic signed [17:0] hue_signed;
   logic [17:0]        hue_base;
   logic [17:0]        hue_sum;
   logic [14:0]        hue_wrap;
   logic [14:0]        hue6_ff;

   always_comb begin
      quo_val    = carry_ff[5].dz ? 12'd0 : quo_ff[5];
      hue_signed = carry_ff[5].neg ? -$signed({6'd0, quo_val}) : $signed({6'd0, quo_val});
      case (carry_ff[5].base)
         HUE_BASE_RED:   hue_base = 18'd0;
         HUE_BASE_GREEN: hue_base = 18'd2 * HUE_SIXTH;
         HUE_BASE_BLUE:  hue_base = 18'd4 * HUE_SIXTH;
         default:        hue_base = 18'd0;
      endcase
      hue_sum = hue_signed + hue_base + {{2{hue_shift_ff[15]}}, hue_shift_ff}
                + 18'd2 * HUE_FULL;
      if (hue_sum >= 18'd4 * HUE_FULL) begin
         hue_wrap = 15'(hue_sum - 18'd4 * HUE_FULL);
      end else if (hue_sum >= 18'd3 * HUE_FULL) begin
         hue_wrap = 15'(hue_sum - 18'd3 * HUE_FULL);
      end else if (hue_sum >= 18'd2 * HUE_FULL) begin
         hue_wrap = 15'(hue_sum - 18'd2 * HUE_FULL);
      end else if (hue_sum >= HUE_FULL) begin
         hue_wrap = 15'(hue_sum - HUE_FULL);
      end else begin
         hue_wrap = hue_sum[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         hue6_ff <= hue_wrap;
      end
   end

   // stage 7: sector and fraction
   logic [2:0]  sector_in;
   logic [14:0] sector_start;
   logic [11:0] hue_frac;
   logic [11:0] frac_in;
   logic [2:0]  sector_ff [7:8];
   logic [11:0] frac_ff;

   always_comb begin
      if (hue6_ff >= 15'(5 * HUE_SIXTH)) begin
         sector_in = 3'd5;
      end else if (hue6_ff >= 15'(4 * HUE_SIXTH)) begin
         sector_in = 3'd4;
      end else if (hue6_ff >= 15'(3 * HUE_SIXTH)) begin
         sector_in = 3'd3;
      end else if (hue6_ff >= 15'(2 * HUE_SIXTH)) begin
         sector_in = 3'd2;
      end else if (hue6_ff >= 15'(HUE_SIXTH)) begin
         sector_in = 3'd1;
      end else begin
         sector_in = 3'd0;
      end
      sector_start = 15'(18'(sector_in) * HUE_SIXTH);
      hue_frac     = 12'(hue6_ff - sector_start);
      frac_in      = sector_in[0] ? 12'(HUE_SIXTH) - hue_frac : hue_frac;
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         sector_ff[7] <= sector_in;
         frac_ff      <= frac_in;
      end
      if (adv[8]) begin
         sector_ff[8] <= sector_ff[7];
      end
   end

   // stage 8: fraction to q16, f * 65536 / 3840
   logic [32:0] frac_prod;
   logic [16:0] frac_q16_ff;

   assign frac_prod = 33'(frac_ff) * RECIP_FIFTEEN;

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         frac_q16_ff <= frac_prod[32:16];
      end
   end

   // stage 9: middle component and sector mapping, bypass without shift
   logic [31:0] mid_prod;
   logic [14:0] mid;
   rgb_type     rgb_in;
   rgb_type     rgb_ff [9:10];
   logic [15:0] alpha_ff [9:13];

   always_comb begin
      mid_prod = 32'(carry_ff[8].d) * 32'(frac_q16_ff);
      mid      = carry_ff[8].mn + mid_prod[30:16];
      if (hue_shift_ff == 16'sd0) begin
         rgb_in = '{r: carry_ff[8].r, g: carry_ff[8].g, b: carry_ff[8].b};
      end else begin
         case (sector_ff[8])
            3'd0:    rgb_in = '{r: carry_ff[8].mx, g: mid, b: carry_ff[8].mn};
            3'd1:    rgb_in = '{r: mid, g: carry_ff[8].mx, b: carry_ff[8].mn};
            3'd2:    rgb_in = '{r: carry_ff[8].mn, g: carry_ff[8].mx, b: mid};
            3'd3:    rgb_in = '{r: carry_ff[8].mn, g: mid, b: carry_ff[8].mx};
            3'd4:    rgb_in = '{r: mid, g: carry_ff[8].mn, b: carry_ff[8].mx};
            default: rgb_in = '{r: carry_ff[8].mx, g: carry_ff[8].mn, b: mid};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         rgb_ff[9]   <= rgb_in;
         alpha_ff[9] <= carry_ff[8].a;
      end
   end

   // alpha rides along to the output
   for (genvar k = 10; k <= 13; k++) begin : g_alpha
      always_ff @(posedge clock) begin
         if (adv[k]) begin
            alpha_ff[k] <= alpha_ff[k-1];
         end
      end
   end

   // stage 10: luma
   logic [26:0] luma_ff;

   always_ff @(posedge clock) begin
      if (adv[10]) begin
         luma_ff   <= 27'(rgb_ff[9].r) * LUMA_R + 27'(rgb_ff[9].g) * LUMA_G
                      + 27'(rgb_ff[9].b) * LUMA_B;
         rgb_ff[10] <= rgb_ff[9];
      end
   end

   // stage 11: saturation partial products, luma split in two halves
   logic signed [16:0] sat_comp;
   logic signed [33:0] luma_lo_prod;
   logic signed [28:0] luma_hi_prod;
   logic signed [33:0] luma_lo_ff;
   logic signed [28:0] luma_hi_ff;
   logic [14:0]        chan10 [0:2];
   logic signed [31:0] own_prod [0:2];
   logic signed [31:0] own_ff   [0:2];

   assign chan10[0] = rgb_ff[10].r;
   assign chan10[1] = rgb_ff[10].g;
   assign chan10[2] = rgb_ff[10].b;

   always_comb begin
      sat_comp     = $signed(17'd4096) - {sat_gain_ff[15], sat_gain_ff};
      luma_lo_prod = sat_comp * $signed({1'b0, luma_ff[15:0]});
      luma_hi_prod = sat_comp * $signed({1'b0, luma_ff[26:16]});
      for (int c = 0; c < 3; c++) begin
         own_prod[c] = sat_gain_ff * $signed({1'b0, chan10[c]});
      end
   end

   always_ff @(posedge clock) begin
      if (adv[11]) begin
         luma_lo_ff <= luma_lo_prod;
         luma_hi_ff <= luma_hi_prod;
         for (int c = 0; c < 3; c++) begin
            own_ff[c] <= own_prod[c];
         end
      end
   end

   // stage 12: inner sum per channel
   logic signed [44:0] inner_in [0:2];
   logic signed [44:0] inner_ff [0:2];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         inner_in[c] = {luma_hi_ff, 16'd0} + {{11{luma_lo_ff[33]}}, luma_lo_ff}
                       + {own_ff[c][31], own_ff[c], 12'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[12]) begin
         for (int c = 0; c < 3; c++) begin
            inner_ff[c] <= inner_in[c];
         end
      end
   end

   // stage 13: contrast product in two halves
   logic signed [39:0] con_lo_in [0:2];
   logic signed [37:0] con_hi_in [0:2];
   logic signed [39:0] con_lo_ff [0:2];
   logic signed [37:0] con_hi_ff [0:2];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         con_lo_in[c] = $signed({1'b0, inner_ff[c][22:0]}) * con_gain_ff;
         con_hi_in[c] = $signed(inner_ff[c][44:23]) * con_gain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[13]) begin
         for (int c = 0; c < 3; c++) begin
            con_lo_ff[c] <= con_lo_in[c];
            con_hi_ff[c] <= con_hi_in[c];
         end
      end
   end

   // stage 14: offset, clamp, output register
   logic signed [61:0] acc [0:2];
   logic [14:0]        clamped [0:2];
   rsp_data_type       rsp_in;
   rsp_data_type       rsp_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc[c] = {con_hi_ff[c][37], con_hi_ff[c], 23'd0}
                  + {{22{con_lo_ff[c][39]}}, con_lo_ff[c]} + offset_ff;
         if (acc[c][61]) begin
            clamped[c] = 15'd0;
         end else if (acc[c][60:36] > 25'(FULL_SCALE)) begin
            clamped[c] = FULL_SCALE;
         end else begin
            clamped[c] = acc[c][50:36];
         end
      end
      rsp_in.red_out   = clamped[0];
      rsp_in.green_out = clamped[1];
      rsp_in.blue_out  = clamped[2];
      rsp_in.alpha_out = alpha_ff[13];
   end

   always_ff @(posedge clock) begin
      if (adv[14]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### hdl/phscb_checker.sv
// port-level checks for the pixel adjust block, bound to its top level
// depends on phscb_pkg and pixel_hue_sat_contrast_bright_assert.svh
`include "pixel_hue_sat_contrast_bright_assert.svh"

module phscb_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input phscb_pkg::rsp_data_type rsp_data,
   input logic                    csr_valid,
   input logic                    csr_ready
);
   import phscb_pkg::*;

   // a stalled result stays put
   `PHSCB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // with the output free the whole pipeline can move, so input is open
   `PHSCB_ASSERT_IMP(a_req_open, clock, reset, !rsp_valid || rsp_ready, req_ready)

   // a full pipeline that is stalled takes nothing
   `PHSCB_ASSERT_NXT(a_no_accept, clock, reset, !req_ready && !rsp_ready && !req_valid, !req_ready || rsp_valid)

   // register writes never wait
   `PHSCB_ASSERT_IMP(a_csr_open, clock, reset, csr_valid, csr_ready)

endmodule

bind pixel_hue_sat_contrast_bright phscb_checker u_phscb_checker (.*);
